// ===== rtl/core/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants of the nearest prototype classifier
// Request and result payloads, register map and distance unit control.
// ----------------------------------------------------------------------------
package npc_pkg;

	// payload field widths
	localparam int CMD_BITS     = 1;
	localparam int NODE_BITS    = 6;
	localparam int DIM_BITS     = 4;
	localparam int VALUE_W      = 16;
	localparam int CLUSTER_BITS = 7;
	localparam int DIST_BITS    = 36;

	// config register widths
	localparam int NODE_CNT_BITS = 7;
	localparam int DIM_CNT_BITS  = 5;

	// saturation ceiling of the distance sum
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	// request commands
	localparam logic [CMD_BITS-1:0] CMD_LOAD  = 1'b0;
	localparam logic [CMD_BITS-1:0] CMD_QUERY = 1'b1;

	// register index (word address bit of paddr)
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_DIM_COUNT  = 1'b1;

	// APB address width
	localparam int PADDR_BITS = 3;

	typedef struct packed {
		logic [CMD_BITS-1:0]       command;
		logic [NODE_BITS-1:0]      node_index;
		logic [DIM_BITS-1:0]       dim_index;
		logic signed [VALUE_W-1:0] element_value;
		logic                      row_last;
	} req_t;

	typedef struct packed {
		logic [CLUSTER_BITS-1:0] cluster_number;
		logic [DIST_BITS-1:0]    min_distance;
	} res_t;

	// control tag traveling with each element pair into the distance unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} dist_ctl_t;

endpackage

// ===== rtl/core/npc_dist.sv =====
// ----------------------------------------------------------------------------
// npc_dist: squared distance accumulator
// Squares one element difference per cycle and sums it over a vector,
// saturating at the distance ceiling.
// ----------------------------------------------------------------------------
module npc_dist #(
	parameter int ELEM_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  npc_pkg::dist_ctl_t                 ctl_s1,
	input  logic signed [ELEM_BITS-1:0]        row_s1,
	input  logic signed [ELEM_BITS-1:0]        wgt_s1,
	output logic                               dist_valid,
	output logic [npc_pkg::DIST_BITS-1:0]      dist_sum
);

	localparam int SQ_BITS  = 2 * ELEM_BITS;
	localparam int SUM_BITS = npc_pkg::DIST_BITS + 1;

	logic signed [ELEM_BITS:0]        diff_c;
	logic [ELEM_BITS:0]               neg_c;
	logic [ELEM_BITS-1:0]             mag_c;
	logic [SQ_BITS-1:0]               sq_c;
	logic [SQ_BITS-1:0]               sq_s2;
	npc_pkg::dist_ctl_t               ctl_s2;
	logic [npc_pkg::DIST_BITS-1:0]    base_c;
	logic [SUM_BITS-1:0]              sum_c;
	logic [npc_pkg::DIST_BITS-1:0]    acc_c;
	logic [npc_pkg::DIST_BITS-1:0]    acc_q;
	logic                             done_q;

	// magnitude of the difference and its square
	always_comb begin
		diff_c = $signed({row_s1[ELEM_BITS-1], row_s1}) - $signed({wgt_s1[ELEM_BITS-1], wgt_s1});
		neg_c  = -diff_c;
		mag_c  = diff_c[ELEM_BITS] ? neg_c[ELEM_BITS-1:0] : diff_c[ELEM_BITS-1:0];
		sq_c   = mag_c * mag_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2 <= sq_c;
	end

	// saturating accumulate; a vector's first element restarts the sum
	always_comb begin
		base_c = ctl_s2.first ? '0 : acc_q;
		sum_c  = {1'b0, base_c} + SUM_BITS'(sq_s2);
		acc_c  = (sum_c >= {1'b0, npc_pkg::DIST_MAX}) ? npc_pkg::DIST_MAX
			: sum_c[npc_pkg::DIST_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= acc_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid & ctl_s2.last;
		end
	end

	assign dist_valid = done_q;
	assign dist_sum   = acc_q;

`ifndef SYNTHESIS
	// a finished sum follows a last element, registered through ctl_s2 and done_q
	a_done_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ctl_s1.valid & ctl_s1.last, 2))
		else $error("distance done without last element");

	// an element marked both first and last forms a one-element sum
	a_single_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid & ctl_s2.first & ctl_s2.last) |=> (acc_q == $past(acc_c)))
		else $error("single-element sum not captured");

	// the ceiling is never exceeded
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid |-> (acc_c <= npc_pkg::DIST_MAX))
		else $error("accumulator above ceiling");
`endif

endmodule

// ===== rtl/core/nearest_prototype_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_prototype_classifier_unit: nearest prototype search, squared distance
// Load requests and query elements without row_last are taken whenever busy is low.
// A query element with row_last starts a search that keeps busy high through the
// run and drain states; the result strobe comes in the cycle that busy falls.
// The search reads one weight element per cycle from the weight memory port.
// Reset clears control and sets config (node_count 64, dim_count 16); memories
// hold undefined data until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module nearest_prototype_classifier_unit #(
	parameter int MAX_NODES  = 64,
	parameter int MAX_DIMS   = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             start,
	input  npc_pkg::req_t                    req,
	output logic                             busy,
	// result channel
	output logic                             done,
	output npc_pkg::res_t                    result,
	// config port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [npc_pkg::PADDR_BITS-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int EW    = (VALUE_BITS < npc_pkg::VALUE_W) ? VALUE_BITS : npc_pkg::VALUE_W;
	localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DEPTH = MAX_NODES * MAX_DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                              state_q;
	logic [npc_pkg::NODE_CNT_BITS-1:0]   node_count_q;
	logic [npc_pkg::DIM_CNT_BITS-1:0]    dim_count_q;
	logic                                cfg_wr;
	logic                                accept;
	logic                                go;
	logic [NW-1:0]                       nodes_last_c;
	logic [DW-1:0]                       dims_last_c;
	logic [NW-1:0]                       nodes_last_q;
	logic [DW-1:0]                       dims_last_q;
	logic [NW-1:0]                       n_q;
	logic [DW-1:0]                       d_q;
	logic                                w_we;
	logic                                r_we;
	logic [AW-1:0]                       w_waddr;
	logic [AW-1:0]                       w_raddr;
	logic [DW-1:0]                       r_waddr;
	logic signed [EW-1:0]                elem_c;
	logic signed [EW-1:0]                weight_mem [DEPTH];
	logic signed [EW-1:0]                row_mem [MAX_DIMS];
	logic signed [EW-1:0]                wgt_s1;
	logic signed [EW-1:0]                row_s1;
	npc_pkg::dist_ctl_t                  ctl_s1;
	logic                                dist_valid;
	logic [npc_pkg::DIST_BITS-1:0]       dist_sum;
	logic [NW-1:0]                       cmp_node_q;
	logic [NW-1:0]                       best_node_q;
	logic [npc_pkg::DIST_BITS-1:0]       best_dist_q;
	logic                                take_c;
	logic [NW-1:0]                       win_node_c;
	logic [npc_pkg::DIST_BITS-1:0]       win_dist_c;
	logic                                cmp_last_c;
	logic                                done_q;
	npc_pkg::res_t                       result_q;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= npc_pkg::NODE_CNT_BITS'(64);
			dim_count_q  <= npc_pkg::DIM_CNT_BITS'(16);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				npc_pkg::REG_NODE_COUNT: node_count_q <= pwdata[npc_pkg::NODE_CNT_BITS-1:0];
				npc_pkg::REG_DIM_COUNT:  dim_count_q  <= pwdata[npc_pkg::DIM_CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			npc_pkg::REG_NODE_COUNT: prdata = 32'(node_count_q);
			npc_pkg::REG_DIM_COUNT:  prdata = 32'(dim_count_q);
			default:                 prdata = '0;
		endcase
	end

	// clamped last node and last dimension of the search
	always_comb begin
		if (node_count_q == '0) begin
			nodes_last_c = '0;
		end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
			nodes_last_c = NW'(MAX_NODES - 1);
		end else begin
			nodes_last_c = NW'(32'(node_count_q) - 32'd1);
		end
		if (dim_count_q == '0) begin
			dims_last_c = '0;
		end else if (32'(dim_count_q) > 32'(MAX_DIMS)) begin
			dims_last_c = DW'(MAX_DIMS - 1);
		end else begin
			dims_last_c = DW'(32'(dim_count_q) - 32'd1);
		end
	end

	// request decode
	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign go     = accept & (req.command == npc_pkg::CMD_QUERY) & req.row_last;
	assign elem_c = req.element_value[EW-1:0];

	assign w_we = accept & (req.command == npc_pkg::CMD_LOAD)
		& (32'(req.node_index) < 32'(MAX_NODES)) & (32'(req.dim_index) < 32'(MAX_DIMS));
	assign r_we = accept & (req.command == npc_pkg::CMD_QUERY)
		& (32'(req.dim_index) < 32'(MAX_DIMS));

	assign w_waddr = AW'(32'(req.node_index) * 32'(MAX_DIMS) + 32'(req.dim_index));
	assign r_waddr = DW'(32'(req.dim_index));
	assign w_raddr = AW'(32'(n_q) * 32'(MAX_DIMS) + 32'(d_q));

	// weight memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_waddr] <= elem_c;
		end
		wgt_s1 <= weight_mem[w_raddr];
	end

	// query row memory
	always_ff @(posedge clk) begin
		if (r_we) begin
			row_mem[r_waddr] <= elem_c;
		end
		row_s1 <= row_mem[d_q];
	end

	// search sequencer: walks nodes and dimensions, one element pair a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			d_q          <= '0;
			nodes_last_q <= '0;
			dims_last_q  <= '0;
			ctl_s1       <= '0;
		end else begin
			ctl_s1 <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q      <= ST_RUN;
						n_q          <= '0;
						d_q          <= '0;
						nodes_last_q <= nodes_last_c;
						dims_last_q  <= dims_last_c;
					end
				end
				ST_RUN: begin
					ctl_s1.valid <= 1'b1;
					ctl_s1.first <= (d_q == '0);
					ctl_s1.last  <= (d_q == dims_last_q);
					if (d_q == dims_last_q) begin
						d_q <= '0;
						if (n_q == nodes_last_q) begin
							state_q <= ST_DRAIN;
						end else begin
							n_q <= n_q + 1'b1;
						end
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cmp_last_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	npc_dist #(
		.ELEM_BITS (EW)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.row_s1     (row_s1),
		.wgt_s1     (wgt_s1),
		.dist_valid (dist_valid),
		.dist_sum   (dist_sum)
	);

	// best-so-far compare; strict less keeps the lowest node on a tie
	always_comb begin
		take_c     = (cmp_node_q == '0) | (dist_sum < best_dist_q);
		win_node_c = take_c ? cmp_node_q : best_node_q;
		win_dist_c = take_c ? dist_sum : best_dist_q;
		cmp_last_c = dist_valid & (cmp_node_q == nodes_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_node_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmp_last_c;
			if (go) begin
				cmp_node_q <= '0;
			end else if (dist_valid) begin
				cmp_node_q <= cmp_node_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dist_valid) begin
			best_node_q <= win_node_c;
			best_dist_q <= win_dist_c;
		end
		if (cmp_last_c) begin
			result_q.cluster_number <= npc_pkg::CLUSTER_BITS'(32'(win_node_c) + 32'd1);
			result_q.min_distance   <= win_dist_c;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// a result closes a drain phase
	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_DRAIN))
		else $error("result without search");

	// no distance arrives while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !dist_valid)
		else $error("distance while idle");

	// walk counters stay within the counts latched at start
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((n_q <= nodes_last_q) && (d_q <= dims_last_q)))
		else $error("search counter out of range");

	// compare counter never passes the last node during a search
	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cmp_node_q <= nodes_last_q))
		else $error("compare counter out of range");
`endif

endmodule

// ===== tb/sv/npc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_checker: scoreboard for the nearest prototype classifier
// Watches the request channel, the register port and the result strobe. It
// keeps its own copy of the prototype table, the query row and the geometry
// registers, works out the nearest node for every row end, and compares each
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module npc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  npc_pkg::req_t                  req,
	input  logic                           done,
	input  npc_pkg::res_t                  result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [npc_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output int                             fail_count,
	output int                             pending
);
	import npc_pkg::*;

	localparam int MAX_NODES = 64;
	localparam int MAX_DIMS  = 16;

	// shadow state
	logic signed [VALUE_W-1:0] proto_w [0:MAX_NODES*MAX_DIMS-1];
	logic signed [VALUE_W-1:0] query_vec [0:MAX_DIMS-1];
	logic [NODE_CNT_BITS-1:0]  node_cfg = 7'd64;
	logic [DIM_CNT_BITS-1:0]   dim_cfg  = 5'd16;

	res_t nearest_q[$];
	res_t want;
	int   mismatches  = 0;
	int   outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	task automatic report_mismatch(string what);
		// keep the log bounded if the block goes badly wrong
		if (mismatches < 100)
			$display("npc_checker: %0s", what);
		mismatches++;
	endtask

	function automatic int clamp_count(int v, int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// sum of squared differences, saturating at the 36-bit ceiling
	function automatic longint row_distance(int node, int dims);
		longint acc;
		longint diff;
		longint sq;
		longint ceiling;
		ceiling = 64'(DIST_MAX);
		acc     = 0;
		for (int d = 0; d < dims; d++) begin
			diff = longint'(query_vec[d]) - longint'(proto_w[node*MAX_DIMS + d]);
			if (diff < 0)
				diff = -diff;
			sq = diff * diff;
			if (sq >= ceiling - acc)
				acc = ceiling;
			else
				acc += sq;
		end
		return acc;
	endfunction

	// strict compare: lowest node wins a tie
	function automatic res_t nearest_prototype();
		int     nodes;
		int     dims;
		int     best_node;
		longint best_d;
		longint d;
		res_t   r;
		nodes     = clamp_count(int'(node_cfg), MAX_NODES);
		dims      = clamp_count(int'(dim_cfg), MAX_DIMS);
		best_node = 0;
		best_d    = row_distance(0, dims);
		for (int n = 1; n < nodes; n++) begin
			d = row_distance(n, dims);
			if (d < best_d) begin
				best_d    = d;
				best_node = n;
			end
		end
		r.cluster_number = 7'(best_node + 1);
		r.min_distance   = 36'(best_d);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cfg = 7'd64;
			dim_cfg  = 5'd16;
			nearest_q.delete();
			outstanding = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_NODE_COUNT, 2'b00})
					node_cfg = pwdata[NODE_CNT_BITS-1:0];
				else if (paddr == {REG_DIM_COUNT, 2'b00})
					dim_cfg = pwdata[DIM_CNT_BITS-1:0];
			end

			// results against the oldest prediction
			if (done) begin
				if (nearest_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result: cluster %0d distance %0d",
						result.cluster_number, result.min_distance));
				end else begin
					want = nearest_q.pop_front();
					if (result.cluster_number !== want.cluster_number)
						report_mismatch($sformatf("cluster_number %0d, expected %0d",
							result.cluster_number, want.cluster_number));
					if (result.min_distance !== want.min_distance)
						report_mismatch($sformatf("min_distance %0d, expected %0d",
							result.min_distance, want.min_distance));
				end
			end

			// accepted request
			if (start && !busy) begin
				if (req.command == CMD_LOAD) begin
					proto_w[int'(req.node_index)*MAX_DIMS + int'(req.dim_index)] =
						req.element_value;
				end else begin
					query_vec[req.dim_index] = req.element_value;
					if (req.row_last)
						nearest_q.push_back(nearest_prototype());
				end
			end

			outstanding = nearest_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_nearest_prototype_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_prototype_classifier_unit: stimulus and verdict
// Loads prototype tables and streams query rows through the command channel,
// first a handful of directed cases (extreme values, ties, ignored row
// marks), then random phases over many node and dimension settings,
// including out-of-range register values. Results are checked by npc_checker.
// ----------------------------------------------------------------------------
module tb_nearest_prototype_classifier_unit;
	import npc_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 36;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	req_t                  req;
	logic                  busy;
	logic                  done;
	res_t                  result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// stimulus bookkeeping
	bit                        w_seen [0:63][0:15];
	logic signed [VALUE_W-1:0] w_shadow [0:63][0:15];
	bit                        q_seen [0:15];
	int                        eff_nodes;
	int                        eff_dims;
	int                        idle_pct;
	int                        burst_left;
	int                        phase_items;

	// node / dimension settings per random phase, extremes and out-of-range first
	int ph_nodes [0:PHASES-1] = '{64, 1, 127, 1, 0, 5, 3, 16, 64, 9};
	int ph_dims  [0:PHASES-1] = '{1, 16, 1, 31, 0, 7, 16, 4, 1, 6};

	nearest_prototype_classifier_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	npc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// mostly random values, with a share of tiny ones to provoke ties
	function automatic logic signed [VALUE_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(15);
		if (pick < 4)
			return 16'(int'($urandom_range(2)) - 1);
		if (pick == 4)
			return 16'sh8000;
		if (pick == 5)
			return 16'sh7FFF;
		return 16'($urandom);
	endfunction

	function automatic req_t make_req(logic [CMD_BITS-1:0] cmd, int node, int dim,
			logic signed [VALUE_W-1:0] val, logic last);
		req_t r;
		r.command       = cmd;
		r.node_index    = 6'(node);
		r.dim_index     = 4'(dim);
		r.element_value = val;
		r.row_last      = last;
		return r;
	endfunction

	// one request, with random sender gaps ahead of it
	task automatic push_request(req_t r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(39) == 0)
				burst_left = 16;
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		phase_items++;
	endtask

	task automatic load_weight(int node, int dim, logic signed [VALUE_W-1:0] val, logic last);
		w_seen[node][dim]   = 1'b1;
		w_shadow[node][dim] = val;
		push_request(make_req(CMD_LOAD, node, dim, val, last));
	endtask

	task automatic query_element(int node, int dim, logic signed [VALUE_W-1:0] val,
			logic last);
		q_seen[dim] = 1'b1;
		push_request(make_req(CMD_QUERY, node, dim, val, last));
	endtask

	// hold off until every search has reported and the block is idle
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic reg_sel, int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(int nodes_raw, int dims_raw);
		drain_results();
		apb_write(REG_NODE_COUNT, nodes_raw);
		apb_write(REG_DIM_COUNT, dims_raw);
		eff_nodes = (nodes_raw == 0) ? 1 : ((nodes_raw > 64) ? 64 : nodes_raw);
		eff_dims  = (dims_raw == 0) ? 1 : ((dims_raw > 16) ? 16 : dims_raw);
	endtask

	// write every table entry the search will read that is still blank
	task automatic fill_prototypes(bit extreme);
		for (int n = 0; n < eff_nodes; n++)
			for (int d = 0; d < eff_dims; d++)
				if (!w_seen[n][d])
					load_weight(n, d, extreme ? 16'sh7FFF : rand_value(), 1'b0);
	endtask

	// full row in shuffled order, last element starts the search
	task automatic send_row();
		int                        order [0:15];
		int                        j;
		int                        tmp;
		int                        style;
		int                        target;
		int                        d;
		logic signed [VALUE_W-1:0] v;
		for (int i = 0; i < 16; i++)
			order[i] = i;
		for (int i = eff_dims - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		style  = $urandom_range(7);
		target = $urandom_range(eff_nodes - 1);
		for (int i = 0; i < eff_dims; i++) begin
			d = order[i];
			case (style)
				0:       v = 16'sh8000;
				1, 2, 3: v = w_shadow[target][d] + 16'(int'($urandom_range(4)) - 2);
				default: v = rand_value();
			endcase
			query_element($urandom_range(63), d, v, i == eff_dims - 1);
		end
	endtask

	initial begin
		int  pick;
		int  dim;
		bit  ready;

		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		idle_pct   = 30;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: two identical nodes, extreme values, ignored row marks
		set_geometry(2, 2);
		load_weight(0, 0, 16'sh7FFF, 1'b0);
		load_weight(0, 1, 16'sh7FFF, 1'b0);
		load_weight(1, 0, 16'sh7FFF, 1'b0);
		load_weight(1, 1, 16'sh7FFF, 1'b0);
		load_weight(63, 15, 16'sh8000, 1'b1);
		query_element(63, 0, 16'sh8000, 1'b0);
		query_element(0, 1, 16'sh8000, 1'b1);
		query_element(5, 1, 16'sh7FFF, 1'b1);
		load_weight(1, 0, 16'sh8000, 1'b1);
		query_element(42, 0, 16'sh8000, 1'b1);
		query_element(0, 0, 16'sh0000, 1'b1);
		query_element(21, 1, 16'sh0001, 1'b1);

		// random phases
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = (ph < 4) ? 30 : ((ph < 7) ? 48 : 0);
			set_geometry(ph_nodes[ph], ph_dims[ph]);
			fill_prototypes(eff_nodes == 1 && eff_dims == 16);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					send_row();
				end else if (pick < 70) begin
					load_weight($urandom_range(63), $urandom_range(15), rand_value(),
						$urandom_range(1));
				end else if (pick < 85) begin
					load_weight($urandom_range(eff_nodes - 1), $urandom_range(eff_dims - 1),
						rand_value(), 1'b0);
				end else begin
					// stray row element; may close the row once every dim is present
					dim   = $urandom_range(15);
					ready = 1'b1;
					for (int d = 0; d < eff_dims; d++)
						if (!q_seen[d] && d != dim)
							ready = 1'b0;
					query_element($urandom_range(63), dim, rand_value(),
						ready ? 1'($urandom_range(1)) : 1'b0);
				end
			end
		end

		drain_results();
		repeat (64 * 16 + 8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
